[rtl/glr_pkg.sv]
// Shared types, constants and helper functions of the grey-level remap block.
package glr_pkg;

  localparam int unsigned TableDepth = 65536;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned FieldW     = 17;
  localparam int unsigned PosW       = 16;
  localparam int unsigned CfgW       = 40;
  localparam int unsigned AccW       = 50;
  localparam int unsigned DenW       = 17;
  localparam int unsigned NumW       = 51;
  localparam int unsigned CntW       = 6;
  localparam int unsigned LinDen     = 65536;

  typedef enum logic [1:0] {
    REQ_MAP   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    FMT_S8  = 2'd0,
    FMT_U8  = 2'd1,
    FMT_S16 = 2'd2,
    FMT_U16 = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    MODE_CLIP   = 2'd0,
    MODE_NORM   = 2'd1,
    MODE_LINEAR = 2'd2,
    MODE_TABLE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FILL_ZERO   = 2'd0,
    FILL_KEEP   = 2'd1,
    FILL_INTERP = 2'd2
  } fill_e;

  typedef enum logic [2:0] {
    CFG_FORMAT     = 3'd0,
    CFG_MODE       = 3'd1,
    CFG_WIN_FIRST  = 3'd2,
    CFG_WIN_SECOND = 3'd3,
    CFG_GAIN       = 3'd4,
    CFG_BIAS       = 3'd5,
    CFG_FILL       = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RD_P = 2'd0,
    RD_A = 2'd1,
    RD_B = 2'd2
  } rd_sel_e;

  typedef enum logic [2:0] {
    RES_CLIP = 3'd0,
    RES_MEM  = 3'd1,
    RES_X    = 3'd2,
    RES_ZERO = 3'd3,
    RES_LO   = 3'd4,
    RES_HI   = 3'd5,
    RES_DIV  = 3'd6
  } res_sel_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_CHK_P,
    ST_RD_A,
    ST_CHK_A,
    ST_RD_B,
    ST_CHK_B,
    ST_MUL1,
    ST_MUL2,
    ST_ADD2,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DIV_END,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic     load_in;
    logic     pt_write;
    logic     clr_start;
    logic     clr_write;
    logic     mem_rd;
    rd_sel_e  rd_sel;
    logic     a_init;
    logic     a_dec;
    logic     b_init;
    logic     b_inc;
    logic     va_load;
    logic     vb_load;
    logic     acc_init;
    logic     mul_en;
    logic     mul_second;
    logic     acc_add;
    logic     div_start;
    logic     div_step;
    logic     res_load;
    res_sel_e res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    mode_e      mode;
    logic [1:0] fill;
    logic       norm_go;
    logic       rd_marked;
    logic       p_zero;
    logic       p_last;
    logic       a_zero;
    logic       b_last;
    logic       div_last;
    logic       clr_last;
    logic       out_free;
  } stat_t;

  function automatic logic signed [FieldW-1:0] type_lo(input fmt_e fmt);
    logic signed [FieldW-1:0] v;
    unique case (fmt)
      FMT_S8:  v = -17'sd128;
      FMT_U8:  v = 17'sd0;
      FMT_S16: v = -17'sd32768;
      FMT_U16: v = 17'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [FieldW-1:0] type_hi(input fmt_e fmt);
    logic signed [FieldW-1:0] v;
    unique case (fmt)
      FMT_S8:  v = 17'sd127;
      FMT_U8:  v = 17'sd255;
      FMT_S16: v = 17'sd32767;
      FMT_U16: v = 17'sd65535;
    endcase
    return v;
  endfunction

  // Truncates to the pixel width and extends back by the type's signedness.
  function automatic logic signed [FieldW-1:0] fit_type(input logic [FieldW-1:0] v,
                                                        input fmt_e fmt);
    logic signed [FieldW-1:0] r;
    unique case (fmt)
      FMT_S8:  r = {{9{v[7]}}, v[7:0]};
      FMT_U8:  r = {9'd0, v[7:0]};
      FMT_S16: r = {v[15], v[15:0]};
      FMT_U16: r = {1'b0, v[15:0]};
    endcase
    return r;
  endfunction

endpackage

[rtl/grey_level_remap.sv]
// Top level of the grey-level remap block: controller and datapath.
//
//   channel  direction  handshake                 payload
//   cfg      in         cfg_we_i                  cfg_index_i, cfg_data_i
//   in       in         in_valid_i / in_stall_o   req_type_i, sample_value_i, point_target_i
//   out      out        out_valid_o / out_stall_i mapped_value_o
//
// One transaction is worked on at a time. Clip, and normalize outside the window, go
// from decode straight to the finish state; direct table lookups first read the entry
// and check its mark; linear mode multiplies and accumulates, then rounds by a shift;
// normalize inside the window does the same but divides, one quotient bit per cycle,
// for 51 bits. Interpolation first reads entries while scanning for the two neighbors,
// then goes on as normalize does. Set and unknown requests go back to idle after decode.
// After reset and after each clear request, the marks of all 65536 entries are swept.
// A stalled output holds the finished result back; the output register keeps its result
// while the next transaction is taken.
module grey_level_remap (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_index_i,
  input  logic [glr_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        req_type_i,
  input  logic signed [glr_pkg::FieldW-1:0] sample_value_i,
  input  logic signed [glr_pkg::FieldW-1:0] point_target_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [glr_pkg::FieldW-1:0] mapped_value_o
);

  glr_pkg::cmd_t  cmd;
  glr_pkg::stat_t stat;

  glr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  glr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .sample_value_i (sample_value_i),
    .point_target_i (point_target_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .mapped_value_o (mapped_value_o)
  );

endmodule

[rtl/glr_datapath.sv]
// Datapath: configuration registers, point memory, multiply-accumulate, divider, output register.
module glr_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  glr_pkg::cmd_t                        cmd_i,
  output glr_pkg::stat_t                       stat_o,
  input  logic                                 cfg_we_i,
  input  logic [2:0]                           cfg_index_i,
  input  logic [glr_pkg::CfgW-1:0]             cfg_data_i,
  input  logic [1:0]                           req_type_i,
  input  logic signed [glr_pkg::FieldW-1:0]    sample_value_i,
  input  logic signed [glr_pkg::FieldW-1:0]    point_target_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic signed [glr_pkg::FieldW-1:0]    mapped_value_o
);

  localparam int unsigned FW = glr_pkg::FieldW;
  localparam int unsigned PW = glr_pkg::PosW;
  localparam int unsigned IW = glr_pkg::IdxW;
  localparam int unsigned AW = glr_pkg::AccW;
  localparam int unsigned NW = glr_pkg::NumW;
  localparam int unsigned DW = glr_pkg::DenW;

  // Configuration registers.
  glr_pkg::fmt_e          fmt_q;
  glr_pkg::mode_e         mode_q;
  logic signed [FW-1:0]   win1_q, win2_q;
  logic signed [31:0]     gain_q;
  logic signed [39:0]     bias_q;
  logic [1:0]             fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= glr_pkg::FMT_U8;
      mode_q <= glr_pkg::MODE_CLIP;
      win1_q <= '0;
      win2_q <= '0;
      gain_q <= 32'sd65536;
      bias_q <= '0;
      fill_q <= glr_pkg::FILL_KEEP;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        glr_pkg::CFG_FORMAT:     fmt_q  <= glr_pkg::fmt_e'(cfg_data_i[1:0]);
        glr_pkg::CFG_MODE:       mode_q <= glr_pkg::mode_e'(cfg_data_i[1:0]);
        glr_pkg::CFG_WIN_FIRST:  win1_q <= cfg_data_i[FW-1:0];
        glr_pkg::CFG_WIN_SECOND: win2_q <= cfg_data_i[FW-1:0];
        glr_pkg::CFG_GAIN:       gain_q <= cfg_data_i[31:0];
        glr_pkg::CFG_BIAS:       bias_q <= cfg_data_i[39:0];
        glr_pkg::CFG_FILL:       fill_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic signed [FW-1:0] lo, hi, span;
  assign lo   = glr_pkg::type_lo(fmt_q);
  assign hi   = glr_pkg::type_hi(fmt_q);
  assign span = hi - lo;

  // Captured transaction.
  logic [1:0]           req_q;
  logic signed [FW-1:0] smp_q, tgt_q, x_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      req_q <= req_type_i;
      smp_q <= sample_value_i;
      tgt_q <= point_target_i;
      x_q   <= glr_pkg::fit_type(sample_value_i, fmt_q);
    end
  end

  // Window.
  logic signed [FW-1:0] vmin, vmax, clip_y;
  logic signed [FW:0]   win_span, x_off, out_span;
  logic signed [FW-1:0] lo_p1;

  assign vmin     = (win1_q < win2_q) ? win1_q : win2_q;
  assign vmax     = (win1_q > win2_q) ? win1_q : win2_q;
  assign clip_y   = (x_q < vmin) ? lo : ((x_q > vmax) ? hi : x_q);
  assign win_span = (FW+1)'(vmax) - (FW+1)'(vmin);
  assign x_off    = (FW+1)'(x_q) - (FW+1)'(vmin);
  assign out_span = (FW+1)'(hi) - (FW+1)'(lo) - 18'sd2;
  assign lo_p1    = lo + 17'sd1;

  // Table positions.
  logic signed [FW-1:0] p_full;
  logic [PW-1:0]        p, last, a_q, b_q, gap, off;
  logic signed [FW:0]   set_pos;
  logic                 set_ok;

  assign p_full  = x_q - lo;
  assign p       = p_full[PW-1:0];
  assign last    = span[PW-1:0];
  assign gap     = b_q - a_q;
  assign off     = p - a_q;
  assign set_pos = (FW+1)'(smp_q) - (FW+1)'(lo);
  assign set_ok  = (set_pos >= 18'sd0) && (set_pos <= (FW+1)'(span))
                   && ({1'b0, set_pos[FW-1:0]} < 18'(glr_pkg::TableDepth));

  always_ff @(posedge clk_i) begin
    if (cmd_i.a_init) a_q <= p - 16'd1;
    else if (cmd_i.a_dec) a_q <= a_q - 16'd1;
    if (cmd_i.b_init) b_q <= p + 16'd1;
    else if (cmd_i.b_inc) b_q <= b_q + 16'd1;
  end

  // Point memory: mark bit on top of the stored value.
  logic [FW:0]    mem_q [glr_pkg::TableDepth];
  logic [FW:0]    rd_q;
  logic           rd_in_q;
  logic [PW-1:0]  rd_pos;
  logic [IW-1:0]  clr_q, wr_addr;
  logic [FW:0]    wr_data;
  logic           wr_en;

  always_comb begin
    unique case (cmd_i.rd_sel)
      glr_pkg::RD_P: rd_pos = p;
      glr_pkg::RD_A: rd_pos = a_q;
      glr_pkg::RD_B: rd_pos = b_q;
      default:       rd_pos = p;
    endcase
  end

  assign wr_en   = (cmd_i.pt_write & set_ok) | cmd_i.clr_write;
  assign wr_addr = cmd_i.pt_write ? set_pos[IW-1:0] : clr_q;
  assign wr_data = cmd_i.pt_write ? {1'b1, tgt_q} : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      rd_q    <= mem_q[rd_pos[IW-1:0]];
      rd_in_q <= ({1'b0, rd_pos} < 17'(glr_pkg::TableDepth));
    end
  end

  logic                 rd_marked;
  logic signed [FW-1:0] rd_val;
  assign rd_marked = rd_in_q & rd_q[FW];
  assign rd_val    = rd_q[FW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_q <= '0;
    end else if (cmd_i.clr_write) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Interpolation end points.
  logic signed [FW-1:0] va_q, vb_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.va_load) va_q <= rd_marked ? rd_val : lo;
    if (cmd_i.vb_load) vb_q <= rd_marked ? rd_val : hi;
  end

  // Multiply-accumulate.
  logic signed [31:0]   opa;
  logic signed [FW:0]   opb;
  logic signed [AW-1:0] prod_q, acc_q;

  always_comb begin
    opa = '0;
    opb = '0;
    case (mode_q) inside
      glr_pkg::MODE_CLIP, glr_pkg::MODE_NORM: begin
        if (!cmd_i.mul_second) begin
          opa = 32'(lo_p1);
          opb = win_span;
        end else begin
          opa = 32'(x_off);
          opb = out_span;
        end
      end
      glr_pkg::MODE_LINEAR: begin
        if (!cmd_i.mul_second) begin
          opa = gain_q;
          opb = (FW+1)'(x_q);
        end
      end
      glr_pkg::MODE_TABLE: begin
        if (!cmd_i.mul_second) begin
          opa = 32'(va_q);
          opb = $signed({2'b00, gap});
        end else begin
          opa = 32'((FW+1)'(vb_q) - (FW+1)'(va_q));
          opb = $signed({2'b00, off});
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= opa * opb;
    if (cmd_i.acc_init) begin
      acc_q <= (mode_q == glr_pkg::MODE_LINEAR) ? AW'(bias_q) : '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
  end

  // Rounded division: (2|num| + den) / (2 den), one quotient bit per cycle.
  logic [DW-1:0]           den;
  logic [AW-1:0]           mag;
  logic [NW-1:0]           num_q;
  logic [DW:0]             dvs_q;
  logic [DW:0]             rem_q;
  logic [DW+1:0]           rem_sh;
  logic [DW+2:0]           diff;
  logic                    neg_q;
  logic [glr_pkg::CntW-1:0] cnt_q;

  always_comb begin
    case (mode_q) inside
      glr_pkg::MODE_CLIP, glr_pkg::MODE_NORM: den = win_span[DW-1:0];
      glr_pkg::MODE_LINEAR:                   den = DW'(glr_pkg::LinDen);
      glr_pkg::MODE_TABLE:                    den = {1'b0, gap};
    endcase
  end

  assign mag    = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
  assign rem_sh = {rem_q, num_q[NW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q <= {mag, 1'b0} + NW'(den);
      dvs_q <= {den, 1'b0};
      neg_q <= acc_q[AW-1];
      rem_q <= '0;
      cnt_q <= glr_pkg::CntW'(NW - 1);
    end else if (cmd_i.div_step) begin
      if (!diff[DW+2]) begin
        rem_q <= diff[DW:0];
        num_q <= {num_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DW:0];
        num_q <= {num_q[NW-2:0], 1'b0};
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  logic [AW-1:0]        lin_mag;
  logic [NW-1:0]        q_mag;
  logic                 q_neg;
  logic signed [NW:0]   quo;
  logic signed [FW-1:0] div_y;

  // Linear mode divides by a power of two, so its rounding is an add and a shift.
  assign lin_mag = (mag + AW'(glr_pkg::LinDen / 2)) >> $clog2(glr_pkg::LinDen);
  assign q_mag   = (mode_q == glr_pkg::MODE_LINEAR) ? NW'(lin_mag) : num_q;
  assign q_neg   = (mode_q == glr_pkg::MODE_LINEAR) ? acc_q[AW-1] : neg_q;
  assign quo     = q_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

  always_comb begin
    div_y = quo[FW-1:0];
    if (mode_q == glr_pkg::MODE_LINEAR) begin
      if (quo > (NW+1)'(hi)) div_y = hi;
      else if (quo < (NW+1)'(lo)) div_y = lo;
    end
  end

  // Result and output register.
  logic signed [FW-1:0] res_mux, res_q, mapped_q;
  logic                 out_valid_q;

  always_comb begin
    unique case (cmd_i.res_sel)
      glr_pkg::RES_CLIP: res_mux = clip_y;
      glr_pkg::RES_MEM:  res_mux = rd_val;
      glr_pkg::RES_X:    res_mux = x_q;
      glr_pkg::RES_ZERO: res_mux = '0;
      glr_pkg::RES_LO:   res_mux = lo;
      glr_pkg::RES_HI:   res_mux = hi;
      glr_pkg::RES_DIV:  res_mux = div_y;
      default:           res_mux = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) res_q <= glr_pkg::fit_type(res_mux, fmt_q);
    if (cmd_i.out_load) mapped_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mapped_value_o = mapped_q;

  always_comb begin
    stat_o.req       = req_q;
    stat_o.mode      = mode_q;
    stat_o.fill      = fill_q;
    stat_o.norm_go   = (mode_q == glr_pkg::MODE_NORM) && (x_q >= vmin) && (x_q <= vmax)
                       && (vmin != vmax);
    stat_o.rd_marked = rd_marked;
    stat_o.p_zero    = (p == '0);
    stat_o.p_last    = (p == last);
    stat_o.a_zero    = (a_q == '0);
    stat_o.b_last    = (b_q == last);
    stat_o.div_last  = (cnt_q == '0);
    stat_o.clr_last  = (clr_q == IW'(glr_pkg::TableDepth - 1));
    stat_o.out_free  = !out_valid_q || !out_stall_i;
  end

endmodule

[rtl/glr_ctrl.sv]
// Controller state machine that sequences the remap datapath.
module glr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  glr_pkg::stat_t stat_i,
  output glr_pkg::cmd_t  cmd_o
);

  glr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glr_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      glr_pkg::ST_CLEAR: begin
        cmd_o.clr_write = 1'b1;
        if (stat_i.clr_last) state_d = glr_pkg::ST_IDLE;
      end
      glr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = glr_pkg::ST_DECODE;
        end
      end
      glr_pkg::ST_DECODE: begin
        case (stat_i.req)
          glr_pkg::REQ_MAP: begin
            case (stat_i.mode) inside
              glr_pkg::MODE_CLIP, glr_pkg::MODE_NORM: begin
                if (stat_i.norm_go) begin
                  state_d = glr_pkg::ST_MUL1;
                end else begin
                  cmd_o.res_load = 1'b1;
                  cmd_o.res_sel  = glr_pkg::RES_CLIP;
                  state_d        = glr_pkg::ST_FINISH;
                end
              end
              glr_pkg::MODE_LINEAR: state_d = glr_pkg::ST_MUL1;
              glr_pkg::MODE_TABLE: begin
                cmd_o.mem_rd = 1'b1;
                cmd_o.rd_sel = glr_pkg::RD_P;
                state_d      = glr_pkg::ST_CHK_P;
              end
            endcase
          end
          glr_pkg::REQ_SET: begin
            cmd_o.pt_write = 1'b1;
            state_d        = glr_pkg::ST_IDLE;
          end
          glr_pkg::REQ_CLEAR: begin
            cmd_o.clr_start = 1'b1;
            state_d         = glr_pkg::ST_CLEAR;
          end
          default: state_d = glr_pkg::ST_IDLE;
        endcase
      end
      glr_pkg::ST_CHK_P: begin
        if (stat_i.rd_marked) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = glr_pkg::RES_MEM;
          state_d        = glr_pkg::ST_FINISH;
        end else begin
          case (stat_i.fill)
            glr_pkg::FILL_KEEP: begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = glr_pkg::RES_X;
              state_d        = glr_pkg::ST_FINISH;
            end
            glr_pkg::FILL_INTERP: begin
              if (stat_i.p_zero) begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_sel  = glr_pkg::RES_LO;
                state_d        = glr_pkg::ST_FINISH;
              end else if (stat_i.p_last) begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_sel  = glr_pkg::RES_HI;
                state_d        = glr_pkg::ST_FINISH;
              end else begin
                cmd_o.a_init = 1'b1;
                state_d      = glr_pkg::ST_RD_A;
              end
            end
            default: begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = glr_pkg::RES_ZERO;
              state_d        = glr_pkg::ST_FINISH;
            end
          endcase
        end
      end
      glr_pkg::ST_RD_A: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.rd_sel = glr_pkg::RD_A;
        state_d      = glr_pkg::ST_CHK_A;
      end
      glr_pkg::ST_CHK_A: begin
        // The lower neighbor is found, or index zero stands in for it.
        if (stat_i.rd_marked || stat_i.a_zero) begin
          cmd_o.va_load = 1'b1;
          cmd_o.b_init  = 1'b1;
          state_d       = glr_pkg::ST_RD_B;
        end else begin
          cmd_o.a_dec = 1'b1;
          state_d     = glr_pkg::ST_RD_A;
        end
      end
      glr_pkg::ST_RD_B: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.rd_sel = glr_pkg::RD_B;
        state_d      = glr_pkg::ST_CHK_B;
      end
      glr_pkg::ST_CHK_B: begin
        if (stat_i.rd_marked || stat_i.b_last) begin
          cmd_o.vb_load = 1'b1;
          state_d       = glr_pkg::ST_MUL1;
        end else begin
          cmd_o.b_inc = 1'b1;
          state_d     = glr_pkg::ST_RD_B;
        end
      end
      glr_pkg::ST_MUL1: begin
        cmd_o.acc_init = 1'b1;
        cmd_o.mul_en   = 1'b1;
        state_d        = glr_pkg::ST_MUL2;
      end
      glr_pkg::ST_MUL2: begin
        cmd_o.mul_en     = 1'b1;
        cmd_o.mul_second = 1'b1;
        cmd_o.acc_add    = 1'b1;
        state_d          = glr_pkg::ST_ADD2;
      end
      glr_pkg::ST_ADD2: begin
        cmd_o.acc_add = 1'b1;
        // Linear mode rounds by a shift and needs no divider pass.
        if (stat_i.mode == glr_pkg::MODE_LINEAR) state_d = glr_pkg::ST_DIV_END;
        else state_d = glr_pkg::ST_DIV_LOAD;
      end
      glr_pkg::ST_DIV_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = glr_pkg::ST_DIV;
      end
      glr_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = glr_pkg::ST_DIV_END;
      end
      glr_pkg::ST_DIV_END: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = glr_pkg::RES_DIV;
        state_d        = glr_pkg::ST_FINISH;
      end
      glr_pkg::ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = glr_pkg::ST_IDLE;
        end
      end
      default: state_d = glr_pkg::ST_IDLE;
    endcase
  end

endmodule
